// ----- rtl/egtf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// egtf_pkg
// Shared types and constants for the edge gated table state machine.
// ----------------------------------------------------------------------------
package egtf_pkg;

	// Default number of transition table slots.
	localparam int TABLE_DEPTH_DEF = 16;

	// Widths fixed by the item format.
	localparam int STATE_W = 8;
	localparam int PIN_W   = 8;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	// Item command codes.
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [PIN_W-1:0]   pin_mask;
		logic [PIN_W-1:0]   input_pins;
		logic [STATE_W-1:0] present_state;
		logic [SLOT_W-1:0]  entry_index;
		logic [STATE_W-1:0] entry_present;
		logic [PIN_W-1:0]   entry_key;
		logic [STATE_W-1:0] entry_next;
	} in_item_t;

	typedef struct packed {
		logic [STATE_W-1:0] next_state;
		logic               matched;
		logic               gate_open;
	} out_item_t;

	// One stored transition.
	typedef struct packed {
		logic [STATE_W-1:0] present;
		logic [PIN_W-1:0]   key;
		logic [STATE_W-1:0] next;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;     // item accepted this cycle
		logic issue;     // read the entry at the scan pointer
		logic take_hit;  // capture the matching entry as the result
		logic load_out;  // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic item_cmd;   // command bit of the item on the input
		logic gate;       // gate condition of the item on the input
		logic limit_zero; // no entries to search
		logic hit;        // the compared entry matches
		logic ptr_done;   // every entry up to the limit has been read
		logic cmp_busy;   // a read is waiting to be compared
		logic out_free;   // output register can take a result
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/edge_gated_table_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// edge_gated_table_fsm
// Programmable table-driven state machine on eight pins, gated by pin edges.
// ----------------------------------------------------------------------------
// Each request is either a table write or a step. A write is accepted, then
// moves through the finish state, where its result is loaded into the output
// register. A step whose gate is closed, or whose search limit is zero, takes
// the same path. A step with an open gate scans the table from entry zero,
// reading one entry per cycle from the single read port of the table memory
// and comparing it in the cycle after the read. The search stops on a match or
// after the last entry up to the limit has been compared, then moves to the
// finish state. A stalled output register holds the request in the finish
// state until it can take the result. One request is in work at a time, but a
// new request is accepted while the previous result still waits in the output
// register. Valid bits for the table are cleared by reset, so no clearing pass
// is needed; entry_count is written through cfg_wr_en and cfg_wr_data, and the
// user must write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module edge_gated_table_fsm #(
	parameter int TABLE_DEPTH = egtf_pkg::TABLE_DEPTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [egtf_pkg::COUNT_W-1:0]   cfg_wr_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire egtf_pkg::in_item_t       in_data,
	output logic                          out_valid,
	input  wire                           out_stall,
	output egtf_pkg::out_item_t           out_data
);

	// Command and status between the controller and the datapath.
	egtf_pkg::dp_cmd_t    cmd;
	egtf_pkg::dp_status_t sts;

	// The controller owns the input handshake and the request sequencing.
	egtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table, the stored pins and the output register.
	egtf_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	// After a request is accepted, the block is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in consecutive cycles");

	// A match is only possible when the gate was open.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.matched || out_data.gate_open))
		else $error("match reported with gate closed");

	// A new result only appears as a request finishes its work.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in work");

endmodule
`default_nettype wire

// ----- rtl/egtf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// egtf_ctrl
// Controller: sequences acceptance, table scan and result hand-off.
// ----------------------------------------------------------------------------
module egtf_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire egtf_pkg::dp_status_t sts,
	output egtf_pkg::dp_cmd_t         cmd
);

	egtf_pkg::state_t state_q;
	egtf_pkg::state_t state_d;
	logic             accept;

	assign in_stall = (state_q != egtf_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.start    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.take_hit = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			egtf_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					if (sts.item_cmd == egtf_pkg::CMD_STEP && sts.gate && !sts.limit_zero) begin
						state_d = egtf_pkg::ST_SCAN;
					end else begin
						state_d = egtf_pkg::ST_FINISH;
					end
				end
			end
			egtf_pkg::ST_SCAN: begin
				// Reads are issued back to back; each is compared in the cycle after it is issued.
				cmd.issue = !sts.ptr_done;
				if (sts.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = egtf_pkg::ST_FINISH;
				end else if (sts.ptr_done && !sts.cmp_busy) begin
					state_d = egtf_pkg::ST_FINISH;
				end
			end
			egtf_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = egtf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = egtf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/egtf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// egtf_dp
// Datapath: transition table, previous pins, scan pointer and result.
// ----------------------------------------------------------------------------
module egtf_dp #(
	parameter int TABLE_DEPTH = egtf_pkg::TABLE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire [egtf_pkg::COUNT_W-1:0]        cfg_wr_data,
	input  wire egtf_pkg::in_item_t            in_data,
	input  wire egtf_pkg::dp_cmd_t             cmd,
	output egtf_pkg::dp_status_t               sts,
	output logic                               out_valid,
	input  wire                                out_stall,
	output egtf_pkg::out_item_t                out_data
);

	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int LIM_W   = (CNT_W > egtf_pkg::COUNT_W) ? CNT_W : egtf_pkg::COUNT_W;
	localparam int SLOTX_W = (IDX_W > egtf_pkg::SLOT_W) ? IDX_W : egtf_pkg::SLOT_W;
	localparam int CMPX_W  = (SLOTX_W > LIM_W) ? SLOTX_W : LIM_W;

	egtf_pkg::entry_t mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [egtf_pkg::COUNT_W-1:0] entry_count_q;
	logic [egtf_pkg::PIN_W-1:0]   prev_pins_q;
	logic [egtf_pkg::STATE_W-1:0] pres_q;
	logic [egtf_pkg::PIN_W-1:0]   key_q;
	logic [LIM_W-1:0]             ptr_q;
	logic [LIM_W-1:0]             limit;
	logic [LIM_W-1:0]             cnt_ext;
	logic [SLOTX_W-1:0]           slot_ext;
	logic                         slot_ok;
	logic [IDX_W-1:0]             waddr;
	logic [IDX_W-1:0]             raddr;

	egtf_pkg::entry_t             rd_entry_s1;
	logic                         rd_valid_s1;
	logic                         cmp_vld_s1;

	egtf_pkg::out_item_t          res_q;
	egtf_pkg::out_item_t          out_q;
	logic                         out_vld_q;

	logic [egtf_pkg::PIN_W-1:0]   mask_pins;
	logic                         gate;

	// Gate: every masked pin has toggled since the stored pins.
	assign mask_pins = in_data.pin_mask & in_data.input_pins;
	assign gate = (((in_data.pin_mask & prev_pins_q) ^ mask_pins) == in_data.pin_mask);

	// Search limit saturates at the table depth.
	assign cnt_ext = LIM_W'(entry_count_q);
	assign limit   = (cnt_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : cnt_ext;

	assign slot_ext = SLOTX_W'(in_data.entry_index);
	assign slot_ok  = (CMPX_W'(slot_ext) < CMPX_W'(TABLE_DEPTH));
	assign waddr    = slot_ext[IDX_W-1:0];
	assign raddr    = ptr_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// Table contents and registered read port.
	always_ff @(posedge clk) begin
		if (cmd.start && in_data.cmd == egtf_pkg::CMD_WRITE && slot_ok) begin
			mem[waddr] <= '{present: in_data.entry_present,
				key: in_data.entry_key, next: in_data.entry_next};
		end
		rd_entry_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			prev_pins_q <= '0;
			ptr_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			cmp_vld_s1  <= cmd.issue;
			rd_valid_s1 <= valid_q[raddr];
			if (cmd.start) begin
				ptr_q <= '0;
				if (in_data.cmd == egtf_pkg::CMD_WRITE) begin
					if (slot_ok) begin
						valid_q[waddr] <= 1'b1;
					end
				end else if (gate) begin
					prev_pins_q <= in_data.input_pins;
				end
			end else if (cmd.issue) begin
				ptr_q <= ptr_q + LIM_W'(1);
			end
		end
	end

	// Step operands and the result being built.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pres_q <= in_data.present_state;
			key_q  <= mask_pins;
			if (in_data.cmd == egtf_pkg::CMD_WRITE) begin
				res_q <= '0;
			end else begin
				res_q.next_state <= in_data.present_state;
				res_q.matched    <= 1'b0;
				res_q.gate_open  <= gate;
			end
		end else if (cmd.take_hit) begin
			res_q.next_state <= rd_entry_s1.next;
			res_q.matched    <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign sts.item_cmd   = in_data.cmd;
	assign sts.gate       = gate;
	assign sts.limit_zero = (limit == '0);
	assign sts.hit        = cmp_vld_s1 && rd_valid_s1 && (rd_entry_s1.present == pres_q)
		&& (rd_entry_s1.key == key_q);
	assign sts.ptr_done   = (ptr_q == limit);
	assign sts.cmp_busy   = cmp_vld_s1;
	assign sts.out_free   = !out_vld_q || !out_stall;

endmodule
`default_nettype wire
